>>> sv/hgrc_pkg.sv
// ---------------------------------------------------------------------------
// hgrc_pkg
// Shared widths, constants, codes and controller/datapath bundles for the
// howl gain ramp calibrator.
// ---------------------------------------------------------------------------
package hgrc_pkg;

    localparam int BLOCK_MAX = 4096;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int SUM_W     = 44;
    localparam int CNT_W     = 13;
    localparam int MS_W      = 31;
    localparam int GAIN_W    = 33;
    localparam int GRS_W     = 20;
    localparam int RUN_W     = 8;
    localparam int MARGIN_W  = 17;
    localparam int STEP_W    = 32;
    localparam int IDX_W     = 3;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int PROD_G_W  = MS_W + GRS_W;
    localparam int PROD_C_W  = GAIN_W + MARGIN_W;
    localparam int PROD_S_W  = STEP_W + CNT_W;
    localparam int GSUM_W    = PROD_S_W + 1;
    localparam int CAND_W    = PROD_C_W - 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    localparam logic [GAIN_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [RUN_W-1:0]  RUN_MAX = 8'hFF;

    localparam logic [GRS_W-1:0]    RST_GRS    = 20'd72253;
    localparam logic [GAIN_W-1:0]   RST_ARM    = 33'h0_8000_0000;
    localparam logic [RUN_W-1:0]    RST_REQ    = 8'd3;
    localparam logic [GAIN_W-1:0]   RST_MINC   = 33'd429496730;
    localparam logic [MARGIN_W-1:0] RST_MARGIN = 17'd52429;
    localparam logic [STEP_W-1:0]   RST_STEP   = 32'd44739;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_NONE   = 2'd3
    } t_command;

    typedef enum logic [IDX_W-1:0] {
        REG_GROWTH_RATIO_SQ = 3'd0,
        REG_ARM_GAIN        = 3'd1,
        REG_REQ_BLOCKS      = 3'd2,
        REG_MIN_CEILING     = 3'd3,
        REG_SAFETY_MARGIN   = 3'd4,
        REG_GAIN_STEP       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic exec;
        logic square;
        logic accum;
        logic mul;
        logic commit;
    } t_dp_ctl;

    typedef struct packed {
        t_command cmd;
        logic     block_end;
        logic     div_done;
        logic     out_free;
    } t_dp_sts;

endpackage

>>> sv/howl_gain_ramp_calibrator.sv
// ---------------------------------------------------------------------------
// howl_gain_ramp_calibrator
// Ramps a test gain block by block and sets a gain ceiling on feedback growth.
// ---------------------------------------------------------------------------
// Slave stream: tuser = command (start, reset, sample), tdata[15:0] = signed
// sample, tlast = last sample of an analysis block. One beat is taken at a time.
// Master stream: one beat per block end, none for other inputs.
// tdata[32:0] = test gain, tdata[65:33] = gain ceiling (both Q1.32),
// tuser = still calibrating.
// Config channel: i_cfg_index selects the register, i_cfg_data is written;
// always ready, write only while the block is idle.
// Sequence: a command is accepted and decoded; a mid-block sample is accepted,
// decoded and accumulated. A block-end sample then runs the divider (one shift
// per quotient bit, then done), a multiply and a commit step; the commit and
// the next input wait until the output register is free.
// The output beat sits in a register; new input is taken while it waits. A
// second result waits in the commit step until the first beat is taken.
// Reset clears the block state, sets the ceiling to 1.0 and loads register
// defaults; there is no clearing pass.
// ---------------------------------------------------------------------------
module howl_gain_ramp_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [hgrc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [15:0] sample
    input  logic [1:0]                          i_s_axis_tuser,  // [1:0] command
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [hgrc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [32:0] gain, [65:33] ceil
    output logic                                o_m_axis_tuser,  // [0] still calibrating
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hgrc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [hgrc_pkg::GAIN_W-1:0]         i_cfg_data
);
    import hgrc_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    hgrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    hgrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_in_last   (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> sv/hgrc_div.sv
// ---------------------------------------------------------------------------
// hgrc_div
// Restoring divider, one quotient bit per cycle: block square sum by count.
// ---------------------------------------------------------------------------
module hgrc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hgrc_pkg::SUM_W-1:0]  i_dividend,
    input  logic [hgrc_pkg::CNT_W-1:0]  i_divisor,
    output logic [hgrc_pkg::SUM_W-1:0]  o_quotient,
    output logic                        o_done
);
    import hgrc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;

    logic [CNT_W:0]       rem_shift;
    logic                 q_bit;
    logic [CNT_W-1:0]     n_rem;

    always_comb begin
        rem_shift = {r_rem, r_quo[SUM_W-1]};
        q_bit     = rem_shift >= {1'b0, r_den};
        if (q_bit) begin
            n_rem = CNT_W'(rem_shift - {1'b0, r_den});
        end else begin
            n_rem = rem_shift[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

>>> sv/hgrc_dp.sv
// ---------------------------------------------------------------------------
// hgrc_dp
// Datapath: registers, block accumulator, products, gain/ceiling update
// and the output register.
// ---------------------------------------------------------------------------
module hgrc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hgrc_pkg::t_dp_ctl                   i_ctl,
    output hgrc_pkg::t_dp_sts                   o_sts,
    input  logic [hgrc_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic [1:0]                          i_in_user,
    input  logic                                i_in_last,
    input  logic                                i_cfg_valid,
    input  logic [hgrc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [hgrc_pkg::GAIN_W-1:0]         i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hgrc_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                o_out_user
);
    import hgrc_pkg::*;

    // registers
    logic [GRS_W-1:0]    r_grs;
    logic [GAIN_W-1:0]   r_arm;
    logic [RUN_W-1:0]    r_req;
    logic [GAIN_W-1:0]   r_minc;
    logic [MARGIN_W-1:0] r_margin;
    logic [STEP_W-1:0]   r_step;

    // input beat
    t_command             r_cmd;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                 r_last;
    logic [SQ_W-1:0]      r_sq;

    // block state
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_n;
    logic [MS_W-1:0]      r_prev;
    logic [GAIN_W-1:0]    r_gain;
    logic [RUN_W-1:0]     r_run;
    logic                 r_active;
    logic [GAIN_W-1:0]    r_ceiling;

    logic [PROD_G_W-1:0]  r_prod_g;
    logic [PROD_C_W-1:0]  r_prod_c;
    logic [PROD_S_W-1:0]  r_prod_s;

    logic                 r_out_valid;
    logic [GAIN_W-1:0]    r_out_gain;
    logic                 r_out_calib;
    logic [GAIN_W-1:0]    r_out_ceil;

    logic [CNT_W-1:0]     n_count;
    logic [SUM_W-1:0]     n_sum;
    logic                 block_end;
    logic [SUM_W-1:0]     quotient;
    logic                 div_done;
    logic [MS_W-1:0]      ms;
    logic signed [2*SAMPLE_W-1:0] sq_full;

    logic                 grew;
    logic [RUN_W-1:0]     n_run;
    logic                 detect;
    logic [CAND_W-1:0]    cand_raw;
    logic [CAND_W-1:0]    cand_min;
    logic [GAIN_W-1:0]    cand;
    logic [GSUM_W-1:0]    gsum;
    logic                 gain_sat;

    assign n_count   = r_count + 1'b1;
    assign n_sum     = r_sum + SUM_W'(r_sq);
    assign block_end = r_last || (n_count == CNT_W'(BLOCK_MAX));
    assign ms        = quotient[MS_W-1:0];
    assign sq_full   = r_sample * r_sample;

    hgrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.accum && block_end),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    always_comb begin
        grew = (r_prev != '0) && (PROD_G_W'({ms, 16'h0000}) > r_prod_g);
        if (!grew) begin
            n_run = '0;
        end else if (r_run == RUN_MAX) begin
            n_run = r_run;
        end else begin
            n_run = r_run + 1'b1;
        end
        detect   = (r_gain >= r_arm) && (n_run >= r_req);
        cand_raw = r_prod_c[PROD_C_W-1:16];
        if (cand_raw < CAND_W'(r_minc)) begin
            cand_min = CAND_W'(r_minc);
        end else begin
            cand_min = cand_raw;
        end
        if (cand_min > CAND_W'(ONE_Q32)) begin
            cand = ONE_Q32;
        end else begin
            cand = GAIN_W'(cand_min);
        end
        gsum     = GSUM_W'(r_gain) + GSUM_W'(r_prod_s);
        gain_sat = gsum >= GSUM_W'(ONE_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grs    <= RST_GRS;
            r_arm    <= RST_ARM;
            r_req    <= RST_REQ;
            r_minc   <= RST_MINC;
            r_margin <= RST_MARGIN;
            r_step   <= RST_STEP;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_GROWTH_RATIO_SQ: r_grs    <= i_cfg_data[GRS_W-1:0];
                REG_ARM_GAIN:        r_arm    <= i_cfg_data;
                REG_REQ_BLOCKS:      r_req    <= i_cfg_data[RUN_W-1:0];
                REG_MIN_CEILING:     r_minc   <= i_cfg_data;
                REG_SAFETY_MARGIN:   r_margin <= i_cfg_data[MARGIN_W-1:0];
                REG_GAIN_STEP:       r_step   <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= t_command'(i_in_user);
            r_sample <= i_in_data[SAMPLE_W-1:0];
            r_last   <= i_in_last;
        end
        if (i_ctl.square) begin
            r_sq <= sq_full[SQ_W-1:0];
        end
        if (i_ctl.accum && block_end) begin
            r_n <= n_count;
        end
        if (i_ctl.mul) begin
            r_prod_g <= r_prev * r_grs;
            r_prod_c <= r_gain * r_margin;
            r_prod_s <= r_step * r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_prev    <= '0;
            r_gain    <= '0;
            r_run     <= '0;
            r_active  <= 1'b0;
            r_ceiling <= ONE_Q32;
        end else if (i_ctl.exec && r_cmd == CMD_RESET) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_prev    <= '0;
            r_gain    <= '0;
            r_run     <= '0;
            r_active  <= 1'b0;
            r_ceiling <= ONE_Q32;
        end else if (i_ctl.exec && r_cmd == CMD_START) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_prev   <= '0;
            r_gain   <= '0;
            r_run    <= '0;
            r_active <= 1'b1;
        end else if (i_ctl.accum) begin
            if (block_end) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end else if (i_ctl.commit && r_active) begin
            r_run <= n_run;
            if (detect) begin
                r_ceiling <= cand;
                r_active  <= 1'b0;
            end else begin
                r_prev <= ms;
                if (gain_sat) begin
                    r_gain    <= ONE_Q32;
                    r_ceiling <= ONE_Q32;
                    r_active  <= 1'b0;
                end else begin
                    r_gain <= gsum[GAIN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            if (!r_active) begin
                r_out_gain  <= ONE_Q32;
                r_out_calib <= 1'b0;
                r_out_ceil  <= r_ceiling;
            end else if (detect) begin
                r_out_gain  <= cand;
                r_out_calib <= 1'b0;
                r_out_ceil  <= cand;
            end else if (gain_sat) begin
                r_out_gain  <= ONE_Q32;
                r_out_calib <= 1'b0;
                r_out_ceil  <= ONE_Q32;
            end else begin
                r_out_gain  <= gsum[GAIN_W-1:0];
                r_out_calib <= 1'b1;
                r_out_ceil  <= r_ceiling;
            end
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.block_end = block_end;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {(OUT_TDATA_W - 2*GAIN_W)'(0), r_out_ceil, r_out_gain};
    assign o_out_user  = r_out_calib;

endmodule

>>> sv/hgrc_ctrl.sv
// ---------------------------------------------------------------------------
// hgrc_ctrl
// Sequencer: input beat, command decode, accumulate, divide, multiply,
// result commit.
// ---------------------------------------------------------------------------
module hgrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hgrc_pkg::t_dp_sts   i_sts,
    output hgrc_pkg::t_dp_ctl   o_ctl
);
    import hgrc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_DEC  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_sts.cmd == CMD_SAMPLE) begin
                    o_ctl.square = 1'b1;
                    n_state      = ST_ACC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACC: begin
                o_ctl.accum = 1'b1;
                n_state     = i_sts.block_end ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = ST_DEC;
            end
            ST_DEC: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> bench/howl_gain_ramp_calibrator_tb.sv
// ---------------------------------------------------------------------------
// howl_gain_ramp_calibrator_tb
// Self-checking bench for the howl gain ramp calibrator. Sample and command
// beats go in on the slave stream while a local model of the ramp, growth
// test and ceiling logic predicts every block-end report. Each report beat on
// the master stream is checked field by field against the oldest prediction.
// Both streams idle at random, with a long output hold-off and register
// changes between phases.
// ---------------------------------------------------------------------------
module howl_gain_ramp_calibrator_tb;
    import hgrc_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_BEATS   = 800;
    localparam int TIMEOUT_CYCLES = 1500000;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              calibrating;
        logic [GAIN_W-1:0] ceiling;
    } t_gain_report;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [GAIN_W-1:0]      cfg_data = '0;

    // register copies
    logic [GRS_W-1:0]    cfg_grs    = RST_GRS;
    logic [GAIN_W-1:0]   cfg_arm    = RST_ARM;
    logic [RUN_W-1:0]    cfg_req    = RST_REQ;
    logic [GAIN_W-1:0]   cfg_minc   = RST_MINC;
    logic [MARGIN_W-1:0] cfg_margin = RST_MARGIN;
    logic [STEP_W-1:0]   cfg_step   = RST_STEP;

    // calibration state
    logic [63:0]       energy_sum = '0;
    logic [63:0]       blk_len    = '0;
    logic [63:0]       last_level = '0;
    logic [63:0]       ramp_gain  = '0;
    logic [RUN_W-1:0]  grow_run   = '0;
    bit                ramp_on    = 1'b0;
    logic [GAIN_W-1:0] ceil_now   = ONE_Q32;

    t_gain_report reports_due[$];

    bit no_gaps = 1'b0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int stall_left = 0;
    int errors = 0;
    int beats_sent = 0;
    int reports_seen = 0;
    int howls_found = 0;
    int reg_writes = 0;

    howl_gain_ramp_calibrator u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_value(input logic [GAIN_W-1:0] lo,
                                                     input logic [GAIN_W-1:0] hi,
                                                     input logic [GAIN_W-1:0] typ);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return lo;
        if (r < 24) return hi;
        return typ;
    endfunction

    // Advances the calibration state by one beat; returns 1 with the report
    // when the beat ends a block.
    function automatic bit ramp_predict(input t_command cmd, input logic [15:0] smp,
                                        input logic lst, output t_gain_report rep);
        logic [63:0] mag;
        logic [63:0] n;
        logic [63:0] ms;
        logic [63:0] cand;
        bit          grew;
        rep = '0;
        case (cmd)
            CMD_RESET: begin
                energy_sum = '0;
                blk_len    = '0;
                last_level = '0;
                ramp_gain  = '0;
                grow_run   = '0;
                ramp_on    = 1'b0;
                ceil_now   = ONE_Q32;
                return 1'b0;
            end
            CMD_START: begin
                ramp_gain  = '0;
                last_level = '0;
                grow_run   = '0;
                energy_sum = '0;
                blk_len    = '0;
                ramp_on    = 1'b1;
                return 1'b0;
            end
            CMD_NONE: return 1'b0;
            default: ;
        endcase

        mag = {48'd0, smp};
        if (smp[15]) mag = 64'h1_0000 - mag;
        energy_sum += mag * mag;
        n = blk_len + 1;
        if (!lst && n < BLOCK_MAX) begin
            blk_len = n;
            return 1'b0;
        end

        ms = energy_sum / n;
        energy_sum = '0;
        blk_len = '0;

        if (!ramp_on) begin
            rep.gain        = ONE_Q32;
            rep.calibrating = 1'b0;
            rep.ceiling     = ceil_now;
            return 1'b1;
        end

        grew = (last_level != 0) && ((ms << 16) > last_level * cfg_grs);
        if (grew) begin
            if (grow_run != RUN_MAX) grow_run++;
        end else begin
            grow_run = '0;
        end

        if (ramp_gain >= cfg_arm && grow_run >= cfg_req) begin
            cand = (ramp_gain * cfg_margin) >> 16;
            if (cand < cfg_minc) cand = cfg_minc;
            if (cand > ONE_Q32) cand = ONE_Q32;
            ceil_now = cand[GAIN_W-1:0];
            ramp_on = 1'b0;
            howls_found++;
            rep.gain = ceil_now;
        end else begin
            last_level = ms;
            ramp_gain += cfg_step * n;
            if (ramp_gain >= ONE_Q32) begin
                ramp_gain = ONE_Q32;
                ceil_now = ONE_Q32;
                ramp_on = 1'b0;
            end
            rep.gain = ramp_gain[GAIN_W-1:0];
        end
        rep.calibrating = ramp_on;
        rep.ceiling     = ceil_now;
        return 1'b1;
    endfunction

    // result check and output pacing
    always @(posedge clk) begin : result_side
        t_gain_report want;
        if (rst_n && m_tvalid && m_tready) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                $error("report beat with nothing expected");
                errors++;
            end else begin
                want = reports_due.pop_front();
                if (m_tdata[GAIN_W-1:0] !== want.gain) begin
                    $error("test_gain: expected %h, got %h", want.gain, m_tdata[GAIN_W-1:0]);
                    errors++;
                end
                if (m_tuser !== want.calibrating) begin
                    $error("still_calibrating: expected %b, got %b",
                           want.calibrating, m_tuser);
                    errors++;
                end
                if (m_tdata[2*GAIN_W-1:GAIN_W] !== want.ceiling) begin
                    $error("gain_ceiling: expected %h, got %h",
                           want.ceiling, m_tdata[2*GAIN_W-1:GAIN_W]);
                    errors++;
                end
            end
        end

        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic send_beat(input t_command cmd, input logic [15:0] smp, input logic lst);
        int gap;
        t_gain_report rep;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        beats_sent++;
        if (ramp_predict(cmd, smp, lst, rep)) reports_due.push_back(rep);
    endtask

    // stop sending and wait until every report is in and the block is quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GROWTH_RATIO_SQ: cfg_grs    = val[GRS_W-1:0];
            REG_ARM_GAIN:        cfg_arm    = val;
            REG_REQ_BLOCKS:      cfg_req    = val[RUN_W-1:0];
            REG_MIN_CEILING:     cfg_minc   = val;
            REG_SAFETY_MARGIN:   cfg_margin = val[MARGIN_W-1:0];
            REG_GAIN_STEP:       cfg_step   = val[STEP_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic load_setup(input logic [GAIN_W-1:0] grs, input logic [GAIN_W-1:0] arm,
                              input logic [GAIN_W-1:0] req, input logic [GAIN_W-1:0] minc,
                              input logic [GAIN_W-1:0] margin,
                              input logic [GAIN_W-1:0] step);
        settle_block();
        write_reg(REG_GROWTH_RATIO_SQ, grs);
        write_reg(REG_ARM_GAIN, arm);
        write_reg(REG_REQ_BLOCKS, req);
        write_reg(REG_MIN_CEILING, minc);
        write_reg(REG_SAFETY_MARGIN, margin);
        write_reg(REG_GAIN_STEP, step);
    endtask

    // start, then blocks of mostly constant level growing 1.5x, with optional noise beats
    task automatic run_howl_session(input int max_blocks, input int max_len,
                                    input int noise_pct);
        int          amp;
        int          len;
        int          b;
        int          i;
        logic [15:0] smp;
        send_beat(CMD_START, 16'($urandom()), 1'($urandom()));
        amp = $urandom_range(1, 300);
        for (b = 0; b < max_blocks && ramp_on; b++) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 4 * max_len);
            else len = $urandom_range(1, max_len);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_beat(t_command'($urandom_range(CMD_SAMPLE, CMD_NONE)),
                              16'($urandom()), 1'($urandom()));
                if ($urandom_range(0, 9) == 0) begin
                    smp = 16'($urandom());
                end else begin
                    smp = 16'(amp);
                    if ($urandom_range(0, 1) == 1) smp = -smp;
                end
                send_beat(CMD_SAMPLE, smp, i == len - 1);
            end
            if (amp >= 32767 || $urandom_range(0, 9) == 0) amp = $urandom_range(1, 60);
            else amp = amp * 3 / 2 + 1;
            if (amp > 32767) amp = 32767;
        end
    endtask

    task automatic test_idle_blocks();
        send_beat(CMD_SAMPLE, 16'h7FFF, 1'b0);
        send_beat(CMD_NONE, 16'hFFFF, 1'b1);
        send_beat(CMD_SAMPLE, 16'h8000, 1'b0);
        send_beat(CMD_SAMPLE, 16'h0000, 1'b1);
        send_beat(CMD_SAMPLE, 16'hFFFF, 1'b1);
    endtask

    task automatic test_commands();
        send_beat(CMD_START, 16'h0000, 1'b0);
        send_beat(CMD_SAMPLE, 16'd1000, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd1000, 1'b1);
        send_beat(CMD_SAMPLE, 16'd2000, 1'b0);
        send_beat(CMD_START, 16'hFFFF, 1'b1);
        send_beat(CMD_SAMPLE, 16'd3000, 1'b1);
        send_beat(CMD_SAMPLE, 16'd0, 1'b1);
        send_beat(CMD_SAMPLE, 16'd7, 1'b0);
        send_beat(CMD_RESET, 16'h5A5A, 1'b0);
        send_beat(CMD_SAMPLE, 16'd7, 1'b1);
        send_beat(CMD_NONE, 16'h1234, 1'b1);
    endtask

    // armed at zero with no growth needed: ceiling falls to the floor, then clamps
    task automatic test_detect_extremes();
        load_setup(33'd0, 33'd0, 33'd0, 33'd0, 33'd65536, 33'hFFFF_FFFF);
        send_beat(CMD_START, 16'd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'h7FFF, 1'b1);
        settle_block();
        write_reg(REG_MIN_CEILING, 33'h1_FFFF_FFFF);
        write_reg(REG_SAFETY_MARGIN, 33'd0);
        send_beat(CMD_START, 16'd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'h8000, 1'b1);
        send_beat(CMD_SAMPLE, 16'h0001, 1'b1);
    endtask

    task automatic test_gain_saturation();
        load_setup(GAIN_W'(RST_GRS), 33'h1_FFFF_FFFF, 33'd255, RST_MINC, 33'h1_FFFF,
                   33'hFFFF_FFFF);
        send_beat(CMD_START, 16'd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'd100, 1'b1);
        send_beat(CMD_SAMPLE, 16'd200, 1'b1);
        send_beat(CMD_SAMPLE, 16'd300, 1'b1);
    endtask

    task automatic test_unused_index();
        int               k;
        logic [IDX_W-1:0] idx;
        settle_block();
        for (k = int'(REG_GAIN_STEP) + 1; k < 2 ** IDX_W; k++) begin
            idx = IDX_W'(k);
            write_reg(idx, {1'b1, $urandom()});
        end
        send_beat(CMD_START, 16'd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'd500, 1'b0);
        send_beat(CMD_SAMPLE, 16'd900, 1'b1);
    endtask

    task automatic test_howl_ramp();
        load_setup(GAIN_W'(RST_GRS), 33'h0_4000_0000, 33'd2, 33'h0_1000_0000,
                   GAIN_W'(RST_MARGIN), 33'h0400_0000);
        run_howl_session(40, 4, 0);
    endtask

    // more than 255 growing blocks before arming: the run must hold at its top
    task automatic test_growth_run_saturation();
        load_setup(33'd0, 33'd2147483400, 33'd255, RST_MINC, 33'd65536, 33'd7158278);
        no_gaps = 1'b1;
        send_beat(CMD_START, 16'd0, 1'b0);
        repeat (302) send_beat(CMD_SAMPLE, 16'd5000, 1'b1);
        no_gaps = 1'b0;
    endtask

    task automatic test_long_block();
        load_setup(GAIN_W'(RST_GRS), RST_ARM, GAIN_W'(RST_REQ), RST_MINC,
                   GAIN_W'(RST_MARGIN), GAIN_W'(RST_STEP));
        no_gaps = 1'b1;
        send_beat(CMD_START, 16'd0, 1'b0);
        repeat (BLOCK_MAX) send_beat(CMD_SAMPLE, 16'h8000, 1'b0);
        send_beat(CMD_SAMPLE, 16'h8000, 1'b1);
        no_gaps = 1'b0;
    endtask

    task automatic test_output_stall();
        settle_block();
        send_beat(CMD_START, 16'd0, 1'b0);
        hold_req++;
        repeat (12) send_beat(CMD_SAMPLE, 16'($urandom()), 1'b1);
    endtask

    task automatic test_random_sessions();
        int first_beat;
        first_beat = beats_sent;
        while (beats_sent - first_beat < RANDOM_BEATS) begin
            load_setup(pick_value(33'd0, 33'hF_FFFF, 33'($urandom_range(65536, 100000))),
                       pick_value(33'd0, 33'h1_0000_0000,
                                  33'($urandom_range(0, 32'h4000_0000))),
                       pick_value(33'd0, 33'd255, 33'($urandom_range(1, 4))),
                       pick_value(33'd0, 33'h1_FFFF_FFFF, {1'b0, $urandom()}),
                       pick_value(33'd0, 33'h1_FFFF, 33'($urandom_range(0, 65536))),
                       pick_value(33'd0, 33'hFFFF_FFFF,
                                  33'($urandom_range(32'h0100_0000, 32'h0800_0000))));
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) run_howl_session(30, 6, 8);
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_blocks();
        test_commands();
        test_detect_extremes();
        test_gain_saturation();
        test_unused_index();
        test_howl_ramp();
        test_growth_run_saturation();
        test_long_block();
        test_output_stall();
        test_random_sessions();
        settle_block();
        $display("ran %0d input beats and %0d register writes across ramp, idle and long blocks",
                 beats_sent, reg_writes);
        $display("checked %0d report beats, %0d of them howl detections",
                 reports_seen, howls_found);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/hgrc_pkg.sv
sv/hgrc_div.sv
sv/hgrc_dp.sv
sv/hgrc_ctrl.sv
sv/howl_gain_ramp_calibrator.sv
bench/howl_gain_ramp_calibrator_tb.sv
